// ===== hw/rtl/edfc_pkg.sv =====
// shared types, register indexes and defaults for the eased dim fade controller
package edfc_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int COORD_BITS_DEF    = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_IN_MS    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_OUT_MS   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_ALPHA    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_COUNT   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAKE_DISTANCE = 3'd4;

    // register defaults
    localparam logic [15:0] FADE_IN_MS_RST    = 16'd10000;
    localparam logic [15:0] FADE_OUT_MS_RST   = 16'd1000;
    localparam logic [7:0]  PEAK_ALPHA_RST    = 8'd240;
    localparam logic [8:0]  LEVEL_COUNT_RST   = 9'd16;
    localparam logic [9:0]  WAKE_DISTANCE_RST = 10'd6;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_PRESS = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         tick_ms;
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
    } in_word_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic       alpha_update;
        logic       finished;
    } out_word_t;

endpackage

// ===== hw/rtl/eased_dim_fade_controller.sv =====
// dimming overlay fade engine with shared divider and multiplier
// sequence from item accept to result valid: FRACTION_BITS divider steps for progress,
// 4 multiplies for the curve and scaling, 8 divider steps for the rounding, 6 control steps;
// once the overlay has closed, an item goes straight to the result step, which waits for
// result_ready while an earlier word is still held; item_ready low while busy
// reset: rst_n asynchronous, loads register defaults and clears fade state, no clearing pass
module eased_dim_fade_controller
    import edfc_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  in_word_t                  item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output out_word_t                 result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int QW       = FRACTION_BITS + 1;
    localparam int PW       = 2 * QW;
    localparam int POS_BITS = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

    localparam logic [QW-1:0] One  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [QW-1:0] Half = {2'b01, {(FRACTION_BITS-1){1'b0}}};
    localparam logic [QW:0]   Two  = {2'b10, {FRACTION_BITS{1'b0}}};

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP  = 4'd1;
    localparam logic [3:0] S_DIVP   = 4'd2;
    localparam logic [3:0] S_BASE   = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_MUL2   = 4'd5;
    localparam logic [3:0] S_EASE   = 4'd6;
    localparam logic [3:0] S_QMUL   = 4'd7;
    localparam logic [3:0] S_LEVEL  = 4'd8;
    localparam logic [3:0] S_AMUL   = 4'd9;
    localparam logic [3:0] S_DIVSET = 4'd10;
    localparam logic [3:0] S_DIVA   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    // what the finished computation is used for
    localparam logic [1:0] M_PLAIN  = 2'd0;
    localparam logic [1:0] M_TICK   = 2'd1;
    localparam logic [1:0] M_WAKE   = 2'd2;
    localparam logic [1:0] M_CLOSED = 2'd3;

    // configuration
    logic [15:0] fade_in_reg, fade_out_reg;
    logic [7:0]  peak_reg;
    logic [8:0]  level_count_reg;
    logic [9:0]  wake_reg;

    // fade state
    logic [3:0]                 state_reg, state_next;
    logic [1:0]                 mode_reg, mode_next;
    logic [15:0]                elapsed_reg, elapsed_next;
    logic                       dismissing_reg, dismissing_next;
    logic [7:0]                 fo_peak_reg, fo_peak_next;
    logic [8:0]                 shown_reg, shown_next;
    logic signed [POS_BITS-1:0] last_x_reg, last_x_next;
    logic signed [POS_BITS-1:0] last_y_reg, last_y_next;
    logic                       skip_reg, skip_next;
    logic                       finished_reg, finished_next;
    logic                       out_valid_reg, out_valid_next;
    out_word_t                  out_reg, out_next;

    // datapath
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [15:0]         rem_reg, rem_next;
    logic [15:0]         dsr_reg, dsr_next;
    logic [7:0]          dvd_reg, dvd_next;
    logic [QW-1:0]       quot_reg, quot_next;
    logic [QW-1:0]       base_reg, base_next;
    logic                low_reg, low_next;
    logic [QW-1:0]       f_reg, f_next;
    logic [7:0]          level_reg, level_next;
    logic [PW-1:0]       prod_reg, prod_next;

    logic [QW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic [16:0]   trial;
    logic          trial_ge;
    logic [16:0]   trial_diff;

    logic [8:0]  lc_clamped;
    logic [7:0]  intervals;
    logic [15:0] dur, el;
    logic [16:0] tick_sum;
    logic [QW:0] base_diff;
    logic [QW-1:0] ease_val, cube_hi;
    logic [PW-1:0] level_sum;
    logic [15:0]   round_num;
    logic [7:0]    alpha_val;
    logic          upd;

    logic signed [POS_BITS-1:0] px, py;
    logic signed [POS_BITS:0]   dx, dy;
    logic [POS_BITS:0]          adx, ady, wake_ext;
    logic                       far;

    assign item_ready   = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        lc_clamped = level_count_reg;
        if (level_count_reg < 9'd2)
        begin
            lc_clamped = 9'd2;
        end
        else if (level_count_reg > 9'd256)
        begin
            lc_clamped = 9'd256;
        end
    end
    assign intervals = 8'(lc_clamped - 9'd1);

    // pointer distance per axis
    assign px       = item.pointer_x[POS_BITS-1:0];
    assign py       = item.pointer_y[POS_BITS-1:0];
    assign dx       = {px[POS_BITS-1], px} - {last_x_reg[POS_BITS-1], last_x_reg};
    assign dy       = {py[POS_BITS-1], py} - {last_y_reg[POS_BITS-1], last_y_reg};
    assign adx      = dx[POS_BITS] ? (~dx + 1'b1) : dx;
    assign ady      = dy[POS_BITS] ? (~dy + 1'b1) : dy;
    assign wake_ext = {{(POS_BITS-9){1'b0}}, wake_reg};
    assign far      = (adx > wake_ext) || (ady > wake_ext);

    assign tick_sum = {1'b0, elapsed_reg} + {9'b0, item.tick_ms};

    always_comb
    begin
        dur = dismissing_reg ? fade_out_reg : fade_in_reg;
        if (dur == 16'd0)
        begin
            dur = 16'd1;
        end
        el = (elapsed_reg > dur) ? dur : elapsed_reg;
    end

    // shared restoring divider step
    assign trial      = {rem_reg, dvd_reg[7]};
    assign trial_ge   = (trial >= {1'b0, dsr_reg});
    assign trial_diff = trial - {1'b0, dsr_reg};

    // shared multiplier
    always_comb
    begin
        mul_a = base_reg;
        mul_b = base_reg;
        case (state_reg)
            S_MUL2:
            begin
                mul_a = prod_reg[FRACTION_BITS +: QW];
            end
            S_QMUL:
            begin
                mul_a = f_reg;
                mul_b = QW'(intervals);
            end
            S_AMUL:
            begin
                mul_a = QW'(dismissing_reg ? fo_peak_reg : peak_reg);
                mul_b = QW'(level_reg);
            end
            default:
            begin
                mul_a = base_reg;
            end
        endcase
    end
    assign mul_p = {{QW{1'b0}}, mul_a} * {{QW{1'b0}}, mul_b};

    // curve pieces
    assign base_diff = Two - {quot_reg, 1'b0};
    assign cube_hi   = prod_reg[FRACTION_BITS +: QW];
    assign ease_val  = low_reg ? prod_reg[FRACTION_BITS-2 +: QW] : (One - (cube_hi >> 1));
    assign level_sum = prod_reg + PW'(Half);
    assign round_num = prod_reg[15:0] + {9'b0, intervals[7:1]};
    assign alpha_val = quot_reg[7:0];
    assign upd       = (shown_reg != {1'b0, alpha_val});

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        elapsed_next    = elapsed_reg;
        dismissing_next = dismissing_reg;
        fo_peak_next    = fo_peak_reg;
        shown_next      = shown_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        skip_next       = skip_reg;
        finished_next   = finished_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_next        = out_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        dvd_next        = dvd_reg;
        quot_next       = quot_reg;
        base_next       = base_reg;
        low_next        = low_reg;
        f_next          = f_reg;
        level_next      = level_reg;
        prod_next       = prod_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_SETUP;
                    mode_next  = M_PLAIN;
                    if (finished_reg)
                    begin
                        mode_next  = M_CLOSED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        case (item.command)
                            CMD_TICK:
                            begin
                                elapsed_next = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
                                mode_next    = M_TICK;
                            end
                            CMD_MOVE:
                            begin
                                last_x_next = px;
                                last_y_next = py;
                                skip_next   = 1'b0;
                                if (!skip_reg && far && !dismissing_reg)
                                begin
                                    mode_next = M_WAKE;
                                end
                            end
                            CMD_PRESS:
                            begin
                                if (!dismissing_reg)
                                begin
                                    mode_next = M_WAKE;
                                end
                            end
                            default:
                            begin
                                mode_next = M_PLAIN;
                            end
                        endcase
                    end
                end
            end
            S_SETUP:
            begin
                // progress of one is loaded as a leading quotient bit
                rem_next   = (el == dur) ? 16'd0 : el;
                quot_next  = {{FRACTION_BITS{1'b0}}, (el == dur)};
                dsr_next   = dur;
                dvd_next   = 8'd0;
                cnt_next   = CNT_BITS'(FRACTION_BITS - 1);
                state_next = S_DIVP;
            end
            S_DIVP, S_DIVA:
            begin
                rem_next  = trial_ge ? trial_diff[15:0] : trial[15:0];
                quot_next = {quot_reg[QW-2:0], trial_ge};
                dvd_next  = {dvd_reg[6:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = (state_reg == S_DIVP) ? S_BASE : S_DONE;
                end
            end
            S_BASE:
            begin
                low_next   = (quot_reg < Half);
                base_next  = (quot_reg < Half) ? quot_reg : base_diff[QW-1:0];
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                prod_next  = mul_p;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod_next  = mul_p;
                state_next = S_EASE;
            end
            S_EASE:
            begin
                f_next     = dismissing_reg ? (One - ease_val) : ease_val;
                state_next = S_QMUL;
            end
            S_QMUL:
            begin
                prod_next  = mul_p;
                state_next = S_LEVEL;
            end
            S_LEVEL:
            begin
                level_next = level_sum[FRACTION_BITS +: 8];
                state_next = S_AMUL;
            end
            S_AMUL:
            begin
                prod_next  = mul_p;
                state_next = S_DIVSET;
            end
            S_DIVSET:
            begin
                // quotient stays below 256, so the top byte starts as remainder
                rem_next   = {8'd0, round_num[15:8]};
                dvd_next   = round_num[7:0];
                dsr_next   = {8'd0, intervals};
                quot_next  = '0;
                cnt_next   = CNT_BITS'(7);
                state_next = S_DIVA;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    case (mode_reg)
                        M_CLOSED:
                        begin
                            out_next = '{alpha: 8'd0, alpha_update: 1'b0, finished: 1'b1};
                        end
                        M_TICK:
                        begin
                            shown_next    = {1'b0, alpha_val};
                            finished_next = finished_reg || (dismissing_reg && alpha_val == 8'd0);
                            out_next      = '{alpha: alpha_val, alpha_update: upd,
                                              finished: finished_next};
                        end
                        M_WAKE:
                        begin
                            // fade-out starts at its own peak
                            fo_peak_next    = alpha_val;
                            elapsed_next    = 16'd0;
                            dismissing_next = 1'b1;
                            shown_next      = {1'b0, alpha_val};
                            finished_next   = (alpha_val == 8'd0);
                            out_next        = '{alpha: alpha_val, alpha_update: upd,
                                                finished: finished_next};
                        end
                        default:
                        begin
                            out_next = '{alpha: alpha_val, alpha_update: 1'b0,
                                         finished: finished_reg};
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_in_reg     <= FADE_IN_MS_RST;
            fade_out_reg    <= FADE_OUT_MS_RST;
            peak_reg        <= PEAK_ALPHA_RST;
            level_count_reg <= LEVEL_COUNT_RST;
            wake_reg        <= WAKE_DISTANCE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FADE_IN_MS:    fade_in_reg     <= cfg_data;
                REG_FADE_OUT_MS:   fade_out_reg    <= cfg_data;
                REG_PEAK_ALPHA:    peak_reg        <= cfg_data[7:0];
                REG_LEVEL_COUNT:   level_count_reg <= cfg_data[8:0];
                REG_WAKE_DISTANCE: wake_reg        <= cfg_data[9:0];
                default:
                begin
                    fade_in_reg <= fade_in_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_PLAIN;
            elapsed_reg    <= 16'd0;
            dismissing_reg <= 1'b0;
            fo_peak_reg    <= 8'd0;
            shown_reg      <= 9'd256;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            skip_reg       <= 1'b1;
            finished_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            elapsed_reg    <= elapsed_next;
            dismissing_reg <= dismissing_next;
            fo_peak_reg    <= fo_peak_next;
            shown_reg      <= shown_next;
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            skip_reg       <= skip_next;
            finished_reg   <= finished_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        dvd_reg   <= dvd_next;
        quot_reg  <= quot_next;
        base_reg  <= base_next;
        low_reg   <= low_next;
        f_reg     <= f_next;
        level_reg <= level_next;
        prod_reg  <= prod_next;
    end

endmodule

// ===== hw/rtl/edfc_checker.sv =====
// port-level checks for the eased dim fade controller, bound to the top level
module edfc_checker
    import edfc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_ready,
    input logic      result_valid,
    input logic      result_ready,
    input out_word_t result
);

    // set once a closing word has been taken
    logic closed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b0;
        end
        else if (result_valid && result_ready && result.finished)
        begin
            closed_reg <= 1'b1;
        end
    end

    // once closed, every later word reports closed with zero opacity
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && closed_reg |->
            result.finished && !result.alpha_update && result.alpha == 8'd0)
        else $error("word after close is not a closed word");

    // a closed overlay shows nothing
    a_finished_dark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.finished |-> result.alpha == 8'd0)
        else $error("finished word with nonzero alpha");

    // one item at a time through the sequencer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while the previous one is in progress");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result word changed or dropped");

endmodule

bind eased_dim_fade_controller edfc_checker u_edfc_checker (.*);
